// ----- hdl/prr_pkg.sv -----
package prr_pkg;

   // width of every value field on the ports and in the stores
   localparam int FIELD_W = 11;
   // width of the length register
   localparam int LEN_W = 11;
   // default capacity and reset length
   localparam int MAX_LEN_DEF = 1024;
   localparam int LEN_RESET = 1024;

   // request kinds carried on req_tuser
   typedef enum logic [1:0] {
      KIND_REVERSE = 2'd0,
      KIND_LOCATE  = 2'd1,
      KIND_FETCH   = 2'd2
   } kind_type;

   // sequencer states
   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_SWAP_A = 5'b00100,
      ST_SWAP_B = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   // strobes from the sequencer to both stores
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

// ----- hdl/prr_store.sv -----
module prr_store
   import prr_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEF
) (
   input  logic                       clock,
   input  mem_ctl_type                mem_ctl,
   input  logic [$clog2(MAX_LEN)-1:0] eas_wr_addr,
   input  logic [FIELD_W-1:0]         eas_wr_data,
   input  logic [$clog2(MAX_LEN)-1:0] soe_wr_addr,
   input  logic [FIELD_W-1:0]         soe_wr_data,
   input  logic [$clog2(MAX_LEN)-1:0] eas_rd_addr0,
   input  logic [$clog2(MAX_LEN)-1:0] eas_rd_addr1,
   input  logic [$clog2(MAX_LEN)-1:0] soe_rd_addr,
   output logic [FIELD_W-1:0]         eas_rd_data0,
   output logic [FIELD_W-1:0]         eas_rd_data1,
   output logic [FIELD_W-1:0]         soe_rd_data
);

   // element held at each position, and position held by each element
   logic [FIELD_W-1:0] eas_mem [MAX_LEN];
   logic [FIELD_W-1:0] soe_mem [MAX_LEN];

   logic [FIELD_W-1:0] eas_q0_ff;
   logic [FIELD_W-1:0] eas_q1_ff;
   logic [FIELD_W-1:0] soe_q_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         eas_mem[eas_wr_addr] <= eas_wr_data;
         soe_mem[soe_wr_addr] <= soe_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         eas_q0_ff <= eas_mem[eas_rd_addr0];
         eas_q1_ff <= eas_mem[eas_rd_addr1];
         soe_q_ff  <= soe_mem[soe_rd_addr];
      end
   end

   assign eas_rd_data0 = eas_q0_ff;
   assign eas_rd_data1 = eas_q1_ff;
   assign soe_rd_data  = soe_q_ff;

endmodule

// ----- hdl/prr_ctrl.sv -----
module prr_ctrl
   import prr_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cfg_write,
   input  logic [LEN_W-1:0]           seq_len,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_kind,
   input  logic [FIELD_W-1:0]         range_start,
   input  logic [FIELD_W-1:0]         range_end,
   input  logic [FIELD_W-1:0]         query_element,
   input  logic [FIELD_W-1:0]         query_position,
   input  logic                       slot_free,
   output logic                       rsp_load,
   output logic [FIELD_W-1:0]         rsp_answer,
   output logic                       rsp_err,
   output mem_ctl_type                mem_ctl,
   output logic [$clog2(MAX_LEN)-1:0] eas_wr_addr,
   output logic [FIELD_W-1:0]         eas_wr_data,
   output logic [$clog2(MAX_LEN)-1:0] soe_wr_addr,
   output logic [FIELD_W-1:0]         soe_wr_data,
   output logic [$clog2(MAX_LEN)-1:0] eas_rd_addr0,
   output logic [$clog2(MAX_LEN)-1:0] eas_rd_addr1,
   output logic [$clog2(MAX_LEN)-1:0] soe_rd_addr,
   input  logic [FIELD_W-1:0]         eas_rd_data0,
   input  logic [FIELD_W-1:0]         eas_rd_data1,
   input  logic [FIELD_W-1:0]         soe_rd_data
);

   localparam int AW = $clog2(MAX_LEN);

   state_type          state_ff, state_in;
   kind_type           kind_ff, kind_in;
   logic               err_ff, err_in;
   logic [FIELD_W-1:0] a_ff, a_in;
   logic [FIELD_W-1:0] b_ff, b_in;
   logic [AW-1:0]      cnt_ff, cnt_in;

   logic               accept;
   logic               start_ok, end_ok, elem_ok, pos_ok;
   logic [FIELD_W-1:0] a_next, b_next;
   logic [FIELD_W-1:0] clear_value;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);

   assign start_ok = (range_start != '0) && (range_start <= seq_len);
   assign end_ok   = (range_end != '0) && (range_end <= seq_len);
   assign elem_ok  = (query_element != '0) && (query_element <= seq_len);
   assign pos_ok   = (query_position != '0) && (query_position <= seq_len);

   assign a_next      = a_ff + FIELD_W'(1);
   assign b_next      = b_ff - FIELD_W'(1);
   assign clear_value = FIELD_W'(cnt_ff) + FIELD_W'(1);

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      err_in   = err_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      cnt_in   = cnt_ff;
      rsp_load = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + AW'(1);
            if (cnt_ff == AW'(MAX_LEN - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               kind_in = kind_type'(req_kind);
               a_in    = range_start;
               b_in    = range_end;
               case (req_kind)
                  KIND_REVERSE: err_in = !(start_ok && end_ok && range_start <= range_end);
                  KIND_LOCATE:  err_in = !elem_ok;
                  KIND_FETCH:   err_in = !pos_ok;
                  default:      err_in = 1'b1;
               endcase
               if (req_kind == KIND_REVERSE && start_ok && end_ok
                   && range_start < range_end) begin
                  state_in = ST_SWAP_A;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SWAP_A: begin
            state_in = ST_SWAP_B;
         end
         ST_SWAP_B: begin
            a_in = a_next;
            b_in = b_next;
            if (a_next < b_next) begin
               state_in = ST_SWAP_A;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            cnt_in   = '0;
         end
      endcase
      // a length write restarts the identity sweep
      if (cfg_write) begin
         state_in = ST_CLEAR;
         cnt_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      err_ff  <= err_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
   end

   // memory port steering
   always_comb begin
      mem_ctl.rd_en = accept || (state_ff == ST_SWAP_B);
      mem_ctl.wr_en = (state_ff == ST_CLEAR) || (state_ff == ST_SWAP_A)
                      || (state_ff == ST_SWAP_B);
      eas_wr_addr   = AW'(a_ff - FIELD_W'(1));
      eas_wr_data   = eas_rd_data1;
      soe_wr_addr   = AW'(eas_rd_data1 - FIELD_W'(1));
      soe_wr_data   = a_ff;
      case (state_ff)
         ST_CLEAR: begin
            eas_wr_addr = cnt_ff;
            eas_wr_data = clear_value;
            soe_wr_addr = cnt_ff;
            soe_wr_data = clear_value;
         end
         ST_SWAP_B: begin
            eas_wr_addr = AW'(b_ff - FIELD_W'(1));
            eas_wr_data = eas_rd_data0;
            soe_wr_addr = AW'(eas_rd_data0 - FIELD_W'(1));
            soe_wr_data = b_ff;
         end
         default: begin
         end
      endcase
      if (state_ff == ST_IDLE) begin
         if (req_kind == KIND_FETCH) begin
            eas_rd_addr0 = AW'(query_position - FIELD_W'(1));
         end else begin
            eas_rd_addr0 = AW'(range_start - FIELD_W'(1));
         end
         eas_rd_addr1 = AW'(range_end - FIELD_W'(1));
      end else begin
         eas_rd_addr0 = AW'(a_next - FIELD_W'(1));
         eas_rd_addr1 = AW'(b_next - FIELD_W'(1));
      end
      soe_rd_addr = AW'(query_element - FIELD_W'(1));
   end

   // answer comes from the read issued when the request was taken
   always_comb begin
      rsp_err    = err_ff;
      rsp_answer = '0;
      if (!err_ff) begin
         case (kind_ff)
            KIND_LOCATE: rsp_answer = soe_rd_data;
            KIND_FETCH:  rsp_answer = eas_rd_data0;
            default:     rsp_answer = '0;
         endcase
      end
   end

endmodule

// ----- hdl/permutation_range_reverser.sv -----
// Permutation range reverser. Holds a permutation of the elements 1..length
// by position, plus its inverse, in two single-write-port memories of
// MAX_LEN entries each, with registered reads. After reset, and after every
// csr write of the length, a sweep writes identity order into both memories;
// during the sweep req_tready stays low. A written length of 0 becomes 1,
// any length above MAX_LEN becomes MAX_LEN. Request kinds on req_tuser:
// 0 reverse positions range_start..range_end, 1 locate query_element
// (answers its position), 2 fetch the element at query_position. Any
// argument of the request's own kind that is 0 or above the length, a
// reverse with start above end, or kind 3 gives arg_error 1 with answer 0
// and leaves the order unchanged. Locate, fetch and every request with an
// argument error go from acceptance to the done state, where the response
// loads once the output slot is free. A reverse of k positions swaps its
// floor(k/2) pairs one after another, each in ST_SWAP_A then ST_SWAP_B,
// since each swap writes two entries of each memory through its single
// write port; the response loads in the cycle before the next request can
// be taken. One request is worked at a time; the response sits in an output
// register so the next request is taken while the previous response waits.
module permutation_range_reverser
   import prr_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // length register write port
   input  logic                 csr_wr_en,
   input  logic [LEN_W-1:0]     csr_wr_data,
   // request channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // range_start[10:0], range_end[21:11], query_element[32:22],
   // query_position[43:33], zero[47:44]
   input  logic [47:0]          req_tdata,
   // req_type[1:0]
   input  logic [1:0]           req_tuser,
   // response channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // answer_value[10:0], zero[15:11]
   output logic [15:0]          rsp_tdata,
   // arg_error[0]
   output logic                 rsp_tuser
);

   localparam int AW = $clog2(MAX_LEN);
   localparam int LEN_RST = (MAX_LEN < LEN_RESET) ? MAX_LEN : LEN_RESET;

   // length register
   logic [LEN_W-1:0]   len_ff, len_in;

   // response output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0] rsp_answer_ff, rsp_answer_in;
   logic               rsp_err_ff, rsp_err_in;

   // sequencer to output register
   logic               slot_free;
   logic               rsp_load;
   logic [FIELD_W-1:0] rsp_answer;
   logic               rsp_err;

   // memory ports
   mem_ctl_type        mem_ctl;
   logic [AW-1:0]      eas_wr_addr, soe_wr_addr;
   logic [FIELD_W-1:0] eas_wr_data, soe_wr_data;
   logic [AW-1:0]      eas_rd_addr0, eas_rd_addr1, soe_rd_addr;
   logic [FIELD_W-1:0] eas_rd_data0, eas_rd_data1, soe_rd_data;

   // saturate the written length into 1..MAX_LEN
   always_comb begin
      len_in = len_ff;
      if (csr_wr_en) begin
         if (csr_wr_data == '0) begin
            len_in = LEN_W'(1);
         end else if (32'(csr_wr_data) > MAX_LEN) begin
            len_in = LEN_W'(MAX_LEN);
         end else begin
            len_in = csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_W'(LEN_RST);
      end else begin
         len_ff <= len_in;
      end
   end

   // output register: a new response loads when the slot is empty or draining
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_answer_in = rsp_answer_ff;
      rsp_err_in    = rsp_err_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_answer_in = rsp_answer;
         rsp_err_in    = rsp_err;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_answer_ff <= rsp_answer_in;
      rsp_err_ff    <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_answer_ff};
   assign rsp_tuser  = rsp_err_ff;

   // request sequencer: sweep, lookups and pairwise swaps
   prr_ctrl #(
      .MAX_LEN (MAX_LEN)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .cfg_write      (csr_wr_en),
      .seq_len        (len_ff),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req_kind       (req_tuser),
      .range_start    (req_tdata[10:0]),
      .range_end      (req_tdata[21:11]),
      .query_element  (req_tdata[32:22]),
      .query_position (req_tdata[43:33]),
      .slot_free      (slot_free),
      .rsp_load       (rsp_load),
      .rsp_answer     (rsp_answer),
      .rsp_err        (rsp_err),
      .mem_ctl        (mem_ctl),
      .eas_wr_addr    (eas_wr_addr),
      .eas_wr_data    (eas_wr_data),
      .soe_wr_addr    (soe_wr_addr),
      .soe_wr_data    (soe_wr_data),
      .eas_rd_addr0   (eas_rd_addr0),
      .eas_rd_addr1   (eas_rd_addr1),
      .soe_rd_addr    (soe_rd_addr),
      .eas_rd_data0   (eas_rd_data0),
      .eas_rd_data1   (eas_rd_data1),
      .soe_rd_data    (soe_rd_data)
   );

   // element-by-position and position-by-element memories
   prr_store #(
      .MAX_LEN (MAX_LEN)
   ) u_store (
      .clock        (clock),
      .mem_ctl      (mem_ctl),
      .eas_wr_addr  (eas_wr_addr),
      .eas_wr_data  (eas_wr_data),
      .soe_wr_addr  (soe_wr_addr),
      .soe_wr_data  (soe_wr_data),
      .eas_rd_addr0 (eas_rd_addr0),
      .eas_rd_addr1 (eas_rd_addr1),
      .soe_rd_addr  (soe_rd_addr),
      .eas_rd_data0 (eas_rd_data0),
      .eas_rd_data1 (eas_rd_data1),
      .soe_rd_data  (soe_rd_data)
   );

endmodule
